FILE: src/pcfb_pkg.sv
// ----------------------------------------------------------------------------
// pcfb_pkg
// Shared types, constants and helpers of the parity checksum frame builder.
// ----------------------------------------------------------------------------
package pcfb_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int CMD_W           = 6;
    localparam int CNT_W           = 6;
    localparam int SUM_W           = 7;
    localparam int BYTE_W          = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int BANKS           = 2;
    localparam int BUSY_W          = $clog2(BANKS + 1);

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_SEND   = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
        logic              overflow;
    } t_out_item;

    // Frame descriptor handed from the front to the back.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic             dropped;
        logic             bank;
    } t_desc;

    // Payload store write request from the front.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [CNT_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HEAD,
        BK_LEN,
        BK_SUM,
        BK_DATA
    } t_bk_state;

    // A 7-bit value followed by its even-parity bit.
    function automatic logic [BYTE_W-1:0] protect(input logic [SUM_W-1:0] v);
        return {v, ^v};
    endfunction

endpackage

FILE: src/pcfb_queue.sv
// ----------------------------------------------------------------------------
// pcfb_queue
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module pcfb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcfb_pkg::t_desc i_push_desc,
    input  logic           i_pop,
    output pcfb_pkg::t_desc o_head,
    output logic           o_full,
    output logic           o_empty
);
    import pcfb_pkg::*;

    t_desc              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/pcfb_front.sv
// ----------------------------------------------------------------------------
// pcfb_front
// Accepts input beats, fills the current payload bank and issues frame
// descriptors on a send.
// ----------------------------------------------------------------------------
module pcfb_front #(
    parameter int MAX_PAYLOAD = pcfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pcfb_pkg::t_in_item  i_item,
    output logic                o_stall,
    input  logic                i_q_full,
    input  logic                i_done,
    output logic                o_push,
    output pcfb_pkg::t_desc     o_desc,
    output pcfb_pkg::t_wr_req   o_wr
);
    import pcfb_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic              r_dropped;
    logic              r_bank;
    logic [BUSY_W-1:0] r_busy;

    logic accept;
    logic append_ok;
    logic busy_inc;

    // Both banks held by the back, or no room for a descriptor: hold off.
    assign o_stall   = i_q_full || (r_busy == BUSY_W'(BANKS));
    assign accept    = i_valid && !o_stall;
    assign append_ok = (r_count < CNT_W'(MAX_PAYLOAD));

    assign o_push       = accept && (i_item.func == FUNC_SEND);
    assign o_desc.cmd   = i_item.cmd;
    assign o_desc.count = r_count;
    assign o_desc.sum   = r_sum;
    assign o_desc.dropped = r_dropped;
    assign o_desc.bank  = r_bank;

    assign o_wr.en   = accept && (i_item.func == FUNC_APPEND) && append_ok;
    assign o_wr.bank = r_bank;
    assign o_wr.addr = r_count;
    assign o_wr.data = i_item.data_byte;

    assign busy_inc = o_push && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_dropped <= 1'b0;
            r_bank    <= 1'b0;
            r_busy    <= '0;
        end else begin
            if (o_wr.en) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + i_item.data_byte[SUM_W-1:0];
            end else if (accept && (i_item.func == FUNC_APPEND)) begin
                r_dropped <= 1'b1;
            end
            if (o_push) begin
                r_count   <= '0;
                r_sum     <= '0;
                r_dropped <= 1'b0;
                if (r_count != '0) begin
                    r_bank <= ~r_bank;
                end
            end
            if (busy_inc && !i_done) begin
                r_busy <= r_busy + 1'b1;
            end else if (i_done && !busy_inc) begin
                r_busy <= r_busy - 1'b1;
            end
        end
    end

endmodule

FILE: src/pcfb_back.sv
// ----------------------------------------------------------------------------
// pcfb_back
// Holds the two-bank payload store and serialises one frame at a time into
// the output register.
// ----------------------------------------------------------------------------
module pcfb_back #(
    parameter int MAX_PAYLOAD = pcfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcfb_pkg::t_wr_req   i_wr,
    input  pcfb_pkg::t_desc     i_head,
    input  logic                i_q_empty,
    output logic                o_pop,
    output logic                o_done,
    output logic                o_valid,
    output pcfb_pkg::t_out_item o_item,
    input  logic                i_stall
);
    import pcfb_pkg::*;

    localparam int MEM_DEPTH = 2 * MAX_PAYLOAD;
    localparam int MW        = $clog2(MEM_DEPTH);

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    t_bk_state         r_state;
    t_bk_state         n_state;
    t_desc             r_desc;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              adv;
    logic              emit;
    t_out_item         emit_item;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_addr;
    logic [MW-1:0]     wr_idx;
    logic [MW-1:0]     rd_idx;
    logic              has_data;
    logic              data_last;

    assign adv       = !r_out_valid || !i_stall;
    assign has_data  = (r_desc.count != '0);
    assign data_last = ((r_idx + 1'b1) == r_desc.count);

    assign wr_idx = MW'(i_wr.addr) + (i_wr.bank ? MW'(MAX_PAYLOAD) : MW'(0));
    assign rd_idx = MW'(rd_addr) + (r_desc.bank ? MW'(MAX_PAYLOAD) : MW'(0));

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_idx] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = BK_HEAD;
                end
            end
            BK_HEAD: begin
                if (adv) begin
                    n_state = has_data ? BK_LEN : BK_IDLE;
                end
            end
            BK_LEN: begin
                if (adv) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                if (adv) begin
                    n_state = BK_DATA;
                end
            end
            BK_DATA: begin
                if (adv && data_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_pop              = 1'b0;
        o_done             = 1'b0;
        emit               = 1'b0;
        emit_item.tx_byte  = '0;
        emit_item.last     = 1'b0;
        emit_item.overflow = r_desc.dropped;
        rd_en              = 1'b0;
        rd_addr            = '0;
        n_idx              = r_idx;
        unique case (r_state)
            BK_IDLE: begin
                o_pop = !i_q_empty;
            end
            BK_HEAD: begin
                emit              = adv;
                emit_item.tx_byte = protect({r_desc.cmd, has_data});
                emit_item.last    = !has_data;
            end
            BK_LEN: begin
                emit              = adv;
                emit_item.tx_byte = protect(SUM_W'(r_desc.count));
            end
            BK_SUM: begin
                emit              = adv;
                emit_item.tx_byte = protect(r_desc.sum);
                rd_en             = adv;
                n_idx             = '0;
            end
            BK_DATA: begin
                emit              = adv;
                emit_item.tx_byte = r_rd_data;
                emit_item.last    = data_last;
                rd_en             = adv && !data_last;
                rd_addr           = r_idx + 1'b1;
                o_done            = adv && data_last;
                if (adv) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_head;
        end
        if (emit) begin
            r_out <= emit_item;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

FILE: src/parity_checksum_frame_builder_top.sv
// A send's descriptor passes through the queue and the back end's descriptor register
// before its header beat goes to the output register. Appends are taken one per cycle
// while not stalled; a frame takes count + 3 output beats (one without payload) and an
// idle state. Input waits while both banks are held by the back end or the queue is full.
// Reset (synchronous, active low) clears counters, flags, queue and sequencer; the
// payload store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// parity_checksum_frame_builder_top
// Serial frame builder: buffers payload bytes and emits a parity-protected
// header, then length, checksum and the payload if any, on each send.
// ----------------------------------------------------------------------------
module parity_checksum_frame_builder_top #(
    parameter int MAX_PAYLOAD = pcfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pcfb_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pcfb_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import pcfb_pkg::*;

    // The front end owns the byte count, running sum and dropped flag of the
    // frame being assembled. It writes payload bytes into one of two banks of
    // the store, so that the next frame can be filled while the back end is
    // still reading the previous one out.
    logic    push;
    t_desc   push_desc;
    t_wr_req wr_req;
    logic    done;

    // The descriptor queue lets a send be taken while the back end is busy.
    t_desc   q_head;
    logic    q_full;
    logic    q_empty;
    logic    pop;

    pcfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in_item),
        .o_stall  (o_in_stall),
        .i_q_full (q_full),
        .i_done   (done),
        .o_push   (push),
        .o_desc   (push_desc),
        .o_wr     (wr_req)
    );

    pcfb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    // The back end sequences header, length, checksum and payload beats
    // into a registered output stage; the store read is issued one beat
    // ahead so that each payload byte is ready when its beat goes out.
    pcfb_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_req),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_done    (done),
        .o_valid   (o_out_valid),
        .o_item    (o_out_item),
        .i_stall   (i_out_stall)
    );

`ifndef SYNTHESIS
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("descriptor queue reports full and empty together");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("back end popped an empty descriptor queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("front end pushed into a full descriptor queue");

    a_write_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> (i_in_item.func == FUNC_APPEND) && !push)
        else $error("payload write without an accepted append");
`endif

endmodule
